// ===== rtl/core/voxel_capsule_region_classifier_core_defines.svh =====
// Assertion macros for the capsule region classifier.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef VOXEL_CAPSULE_REGION_CLASSIFIER_CORE_DEFINES_SVH
`define VOXEL_CAPSULE_REGION_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define VCRC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vcrc: assertion failed");

`define VCRC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vcrc: implication failed");

`else

`define VCRC_ASSERT(name, prop)

`define VCRC_ASSERT_IMP(name, ante, cons)

`endif

`endif

// ===== rtl/core/vcrc_pkg.sv =====
package vcrc_pkg;

  localparam int COORD_W      = 16;
  localparam int LABEL_W      = 16;
  localparam int EDGE_LABEL_W = 8;
  localparam int RSQ_W        = 34;
  localparam int AXIS_W       = COORD_W + 1;
  localparam int DIFF_W       = COORD_W + 1;   // pos - head
  localparam int TAIL_W       = COORD_W + 2;   // pos - head - axis
  localparam int DSQ_W        = 2 * DIFF_W;
  localparam int ESQ_W        = 2 * TAIL_W;
  localparam int ASQ_W        = 2 * AXIS_W;
  localparam int PRD_W        = AXIS_W + DIFF_W;
  localparam int DD_W         = DSQ_W + 2;
  localparam int EE_W         = ESQ_W + 2;
  localparam int AA_W         = ASQ_W + 2;
  localparam int DOT_W        = PRD_W + 2;
  localparam int CMP_W        = (EE_W > RSQ_W) ? EE_W : RSQ_W;
  localparam int SC_W         = (AA_W > DOT_W - 1) ? AA_W : DOT_W - 1;
  localparam int MUL_W        = (DD_W > RSQ_W) ? DD_W : RSQ_W;
  localparam int HALF_W       = (MUL_W + 1) / 2;
  localparam int OPND_W       = 2 * HALF_W;
  localparam int WPROD_W      = 2 * OPND_W;

  localparam int IN_FIELDS_W  = LABEL_W + 3 * COORD_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = RSQ_W;
  localparam int NSTG         = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_X   = 3'd0,
    REG_HEAD_Y   = 3'd1,
    REG_HEAD_Z   = 3'd2,
    REG_AXIS_X   = 3'd3,
    REG_AXIS_Y   = 3'd4,
    REG_AXIS_Z   = 3'd5,
    REG_RADIUS_SQ = 3'd6,
    REG_EDGE_LABEL = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    HIT_BG    = 3'd0,
    HIT_LABEL = 3'd1,
    HIT_HEAD  = 3'd2,
    HIT_TAIL  = 3'd3,
    HIT_CYL   = 3'd4,
    HIT_OUT   = 3'd5
  } hit_e;

  // stage enables for the split multiplier
  typedef struct packed {
    logic part;
    logic sum;
  } mul_en_t;

endpackage

// ===== rtl/core/voxel_capsule_region_classifier_core.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: voxel_label, pos_x, pos_y, pos_z
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: in_region, hit_code
// cfg       in   cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
// Seven register stages; one word accepted per cycle while the output is not stalled.
// The cylinder test uses three split 36x36 multiplies.
// Each stage takes a new word when empty or when the next stage moves, so
// bubbles close up under output stall and nothing is dropped or repeated.
// Reset clears the valid bits and loads the register defaults (edge label 2).
`include "voxel_capsule_region_classifier_core_defines.svh"

module voxel_capsule_region_classifier_core import vcrc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] voxel_label, [31:16] pos_x, [47:32] pos_y, [63:48] pos_z
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] in_region, [3:1] hit_code, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // configuration
  logic signed [COORD_W-1:0]      head_q [3];
  logic signed [AXIS_W-1:0]       axis_q [3];
  logic [RSQ_W-1:0]               rsq_q;
  logic [EDGE_LABEL_W-1:0]        edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        head_q[i] <= '0;
        axis_q[i] <= '0;
      end
      rsq_q  <= '0;
      edge_q <= EDGE_LABEL_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HEAD_X:     head_q[0] <= cfg_wdata_i[COORD_W-1:0];
        REG_HEAD_Y:     head_q[1] <= cfg_wdata_i[COORD_W-1:0];
        REG_HEAD_Z:     head_q[2] <= cfg_wdata_i[COORD_W-1:0];
        REG_AXIS_X:     axis_q[0] <= cfg_wdata_i[AXIS_W-1:0];
        REG_AXIS_Y:     axis_q[1] <= cfg_wdata_i[AXIS_W-1:0];
        REG_AXIS_Z:     axis_q[2] <= cfg_wdata_i[AXIS_W-1:0];
        REG_RADIUS_SQ:  rsq_q     <= cfg_wdata_i[RSQ_W-1:0];
        REG_EDGE_LABEL: edge_q    <= cfg_wdata_i[EDGE_LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // decided flag and code travel along; stage 7 only needs the code
  logic dec_q  [NSTG-1];
  hit_e code_q [NSTG];

  // stage 1: label checks, offsets from head and tail
  logic [LABEL_W-1:0]        label;
  logic signed [COORD_W-1:0] pos [3];
  logic                      lbl_zero, lbl_match;
  logic signed [DIFF_W-1:0]  d_d [3];
  logic signed [TAIL_W-1:0]  e_d [3];
  logic signed [DIFF_W-1:0]  d_q [3];
  logic signed [TAIL_W-1:0]  e_q [3];

  assign label  = s_axis_tdata[LABEL_W-1:0];
  assign pos[0] = s_axis_tdata[LABEL_W +: COORD_W];
  assign pos[1] = s_axis_tdata[LABEL_W + COORD_W +: COORD_W];
  assign pos[2] = s_axis_tdata[LABEL_W + 2 * COORD_W +: COORD_W];

  assign lbl_zero  = (label == '0);
  assign lbl_match = (label == LABEL_W'(edge_q));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i] = DIFF_W'(pos[i]) - DIFF_W'(head_q[i]);
      e_d[i] = TAIL_W'(pos[i]) - TAIL_W'(head_q[i]) - TAIL_W'(axis_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dec_q[0]  <= lbl_zero || lbl_match;
      code_q[0] <= lbl_zero ? HIT_BG : (lbl_match ? HIT_LABEL : HIT_OUT);
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= d_d[i];
        e_q[i] <= e_d[i];
      end
    end
  end

  // stage 2: squares and axis products
  logic signed [DSQ_W-1:0] dsq_q [3];
  logic signed [ESQ_W-1:0] esq_q [3];
  logic signed [ASQ_W-1:0] asq_q [3];
  logic signed [PRD_W-1:0] ad_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dec_q[1]  <= dec_q[0];
      code_q[1] <= code_q[0];
      for (int i = 0; i < 3; i++) begin
        dsq_q[i] <= DSQ_W'(d_q[i]) * DSQ_W'(d_q[i]);
        esq_q[i] <= ESQ_W'(e_q[i]) * ESQ_W'(e_q[i]);
        asq_q[i] <= ASQ_W'(axis_q[i]) * ASQ_W'(axis_q[i]);
        ad_q[i]  <= PRD_W'(axis_q[i]) * PRD_W'(d_q[i]);
      end
    end
  end

  // stage 3: sums of three
  logic [DD_W-1:0]         dd_q;
  logic [EE_W-1:0]         ee_q;
  logic [AA_W-1:0]         aa_q;
  logic signed [DOT_W-1:0] dot_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dec_q[2]  <= dec_q[1];
      code_q[2] <= code_q[1];
      dd_q  <= DD_W'(dsq_q[0]) + DD_W'(dsq_q[1]) + DD_W'(dsq_q[2]);
      ee_q  <= EE_W'(esq_q[0]) + EE_W'(esq_q[1]) + EE_W'(esq_q[2]);
      aa_q  <= AA_W'(asq_q[0]) + AA_W'(asq_q[1]) + AA_W'(asq_q[2]);
      dot_q <= DOT_W'(ad_q[0]) + DOT_W'(ad_q[1]) + DOT_W'(ad_q[2]);
    end
  end

  // stage 4: sphere tests, projection range, multiplier operands
  logic  hit_head, hit_tail, aa_zero, s_neg, s_big, dec4_d;
  hit_e  code4_d;
  logic [OPND_W-1:0] op_dd_q, op_aa_q, op_ss_q;

  assign hit_head = CMP_W'(dd_q) <= CMP_W'(rsq_q);
  assign hit_tail = CMP_W'(ee_q) <= CMP_W'(rsq_q);
  assign aa_zero  = (aa_q == '0);
  assign s_neg    = dot_q[DOT_W-1];
  assign s_big    = SC_W'(dot_q[DOT_W-2:0]) > SC_W'(aa_q);

  always_comb begin
    dec4_d  = 1'b1;
    code4_d = code_q[2];
    if (!dec_q[2]) begin
      if (hit_head) begin
        code4_d = HIT_HEAD;
      end else if (hit_tail) begin
        code4_d = HIT_TAIL;
      end else if (aa_zero || s_neg || s_big) begin
        code4_d = HIT_OUT;
      end else begin
        dec4_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      dec_q[3]  <= dec4_d;
      code_q[3] <= code4_d;
      op_dd_q   <= OPND_W'(dd_q);
      op_aa_q   <= OPND_W'(aa_q);
      op_ss_q   <= OPND_W'(dot_q[DOT_W-2:0]);
    end
  end

  // stages 5 and 6: D*A, R*A, s*s
  mul_en_t             mul_en;
  logic [WPROD_W-1:0]  p_da, p_ra, p_ss;

  assign mul_en.part = en[4];
  assign mul_en.sum  = en[5];

  vcrc_wide_mul u_mul_da (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (op_dd_q),
    .b_i   (op_aa_q),
    .p_o   (p_da)
  );

  vcrc_wide_mul u_mul_ra (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (OPND_W'(rsq_q)),
    .b_i   (op_aa_q),
    .p_o   (p_ra)
  );

  vcrc_wide_mul u_mul_ss (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (op_ss_q),
    .b_i   (op_ss_q),
    .p_o   (p_ss)
  );

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      dec_q[4]  <= dec_q[3];
      code_q[4] <= code_q[3];
    end
    if (en[5]) begin
      dec_q[5]  <= dec_q[4];
      code_q[5] <= code_q[4];
    end
  end

  // stage 7: cylinder test D*A <= R*A + s*s, output register
  logic in_cyl;
  logic in_region;

  assign in_cyl = {1'b0, p_da} <= ((WPROD_W + 1)'(p_ra) + (WPROD_W + 1)'(p_ss));

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      code_q[6] <= dec_q[5] ? code_q[5] : (in_cyl ? HIT_CYL : HIT_OUT);
    end
  end

  assign in_region = (code_q[6] == HIT_LABEL) || (code_q[6] == HIT_HEAD) ||
                     (code_q[6] == HIT_TAIL)  || (code_q[6] == HIT_CYL);

  assign m_axis_tvalid = v_q[NSTG-1];
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, code_q[6], in_region};

  // a free output slot opens the whole chain
  `VCRC_ASSERT_IMP(a_ready_chain, m_axis_tready, s_axis_tready)

  // undecided words reaching the multipliers have a nonzero axis
  `VCRC_ASSERT_IMP(a_cyl_axis, v_q[3] && !dec_q[3], op_aa_q != '0)

  // only the six defined codes leave the block
  `VCRC_ASSERT_IMP(a_out_code, m_axis_tvalid, code_q[6] <= HIT_OUT)

endmodule

// ===== rtl/core/vcrc_wide_mul.sv =====
// Unsigned OPND_W x OPND_W multiply over two stages:
// four half-width partial products, then one shifted sum.
module vcrc_wide_mul import vcrc_pkg::*; (
  input  logic                clk_i,
  input  mul_en_t             en_i,
  input  logic [OPND_W-1:0]   a_i,
  input  logic [OPND_W-1:0]   b_i,
  output logic [WPROD_W-1:0]  p_o
);

  logic [HALF_W-1:0]   a_lo, a_hi, b_lo, b_hi;
  logic [OPND_W-1:0]   ll_d, lh_d, hl_d, hh_d;
  logic [OPND_W-1:0]   ll_q, lh_q, hl_q, hh_q;
  logic [WPROD_W-1:0]  p_d, p_q;

  assign a_lo = a_i[HALF_W-1:0];
  assign a_hi = a_i[OPND_W-1:HALF_W];
  assign b_lo = b_i[HALF_W-1:0];
  assign b_hi = b_i[OPND_W-1:HALF_W];

  assign ll_d = OPND_W'(a_lo) * OPND_W'(b_lo);
  assign lh_d = OPND_W'(a_lo) * OPND_W'(b_hi);
  assign hl_d = OPND_W'(a_hi) * OPND_W'(b_lo);
  assign hh_d = OPND_W'(a_hi) * OPND_W'(b_hi);

  always_ff @(posedge clk_i) begin
    if (en_i.part) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
    end
  end

  // hh and ll do not overlap, so they concatenate
  assign p_d = {hh_q, ll_q}
             + {{HALF_W{1'b0}}, lh_q, {HALF_W{1'b0}}}
             + {{HALF_W{1'b0}}, hl_q, {HALF_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== bench/voxel_capsule_region_classifier_core_tb.sv =====
`timescale 1ns / 1ps

module voxel_capsule_region_classifier_core_tb import vcrc_pkg::*;;

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam int     PHASES    = 10;
  localparam int     PHASE_LEN = 153;

  // lowest bits first: label, x, y, z
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_x;
    logic [LABEL_W-1:0]        label;
  } voxel_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // capsule registers as the block should hold them
  logic signed [COORD_W-1:0] head_pos [3] = '{default: '0};
  logic signed [AXIS_W-1:0]  axis_vec [3] = '{default: '0};
  logic [RSQ_W-1:0]          radius_sq = '0;
  logic [EDGE_LABEL_W-1:0]   own_label = EDGE_LABEL_W'(2);

  voxel_t voxel_queue [$];
  hit_e   expected_codes [$];
  int     near_span = 0;
  int     send_gap_pct = 0;
  int     recv_stall_pct = 0;
  logic   rx_hold = 1'b0;
  int     voxels_sent = 0;
  int     results_seen = 0;
  int     mismatches = 0;
  int     settings_used = 0;
  int     hit_seen [6] = '{default: 0};

  voxel_capsule_region_classifier_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic hit_e classify_voxel(voxel_t v);
    logic signed [COORD_W-1:0] p [3];
    logic signed [COORD_W+3:0] d [3];
    logic signed [COORD_W+3:0] e [3];
    logic signed [127:0]       dd, ee, aa, dot, r2;
    p[0] = v.pos_x;
    p[1] = v.pos_y;
    p[2] = v.pos_z;
    if (v.label == '0) return HIT_BG;
    if (v.label == LABEL_W'(own_label)) return HIT_LABEL;
    dd = '0;
    ee = '0;
    aa = '0;
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = p[i] - head_pos[i];
      e[i] = d[i] - axis_vec[i];
      dd += d[i] * d[i];
      ee += e[i] * e[i];
      aa += axis_vec[i] * axis_vec[i];
      dot += axis_vec[i] * d[i];
    end
    r2 = $signed({{(128 - RSQ_W){1'b0}}, radius_sq});
    if (dd <= r2) return HIT_HEAD;
    if (ee <= r2) return HIT_TAIL;
    // a zero axis leaves only the head sphere
    if (aa == 0) return HIT_OUT;
    if (dot < 0 || dot > aa) return HIT_OUT;
    // squared distance from the axis line, scaled by |a|^2
    if (dd * aa <= r2 * aa + dot * dot) return HIT_CYL;
    return HIT_OUT;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  // points mostly scattered around the capsule so every test gets exercised
  function automatic voxel_t random_voxel();
    voxel_t                    v;
    logic signed [COORD_W-1:0] p [3];
    int unsigned               pick;
    longint                    t, off;
    int                        span;
    pick = $urandom_range(99);
    v.label = LABEL_W'($urandom);
    if (pick < 6) begin
      v.label = '0;
    end else if (pick < 12) begin
      v.label = LABEL_W'(own_label);
    end else if (pick < 17) begin
      // low byte matches, upper bits do not
      v.label = LABEL_W'(($urandom_range(1, 255) << EDGE_LABEL_W) | own_label);
    end
    span = near_span * 13 / 10 + 2;
    t = longint'($urandom_range(320)) - 32;
    for (int i = 0; i < 3; i++) begin
      off = longint'($urandom_range(2 * span)) - span;
      p[i] = sat_coord(head_pos[i] + (axis_vec[i] * t) / 256 + off);
    end
    if ($urandom_range(99) < 15) begin
      p[0] = COORD_W'($urandom);
      p[1] = COORD_W'($urandom);
      p[2] = COORD_W'($urandom);
    end
    v.pos_x = p[0];
    v.pos_y = p[1];
    v.pos_z = p[2];
    return v;
  endfunction

  function automatic void queue_voxel(int lbl, int x, int y, int z);
    voxel_t v;
    v.label = LABEL_W'(lbl);
    v.pos_x = COORD_W'(x);
    v.pos_y = COORD_W'(y);
    v.pos_z = COORD_W'(z);
    voxel_queue.push_back(v);
  endfunction

  // field in the low bits; optionally junk above the register width
  function automatic logic [CFG_DATA_W-1:0] pad_word(longint field, int w, bit dirty);
    logic [CFG_DATA_W-1:0] mask, word;
    mask = (CFG_DATA_W'(1) << w) - 1;
    word = CFG_DATA_W'(field) & mask;
    if (dirty) word = word | (CFG_DATA_W'({$urandom, $urandom}) & ~mask);
    return word;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_HEAD_X:     head_pos[0] = val[COORD_W-1:0];
      REG_HEAD_Y:     head_pos[1] = val[COORD_W-1:0];
      REG_HEAD_Z:     head_pos[2] = val[COORD_W-1:0];
      REG_AXIS_X:     axis_vec[0] = val[AXIS_W-1:0];
      REG_AXIS_Y:     axis_vec[1] = val[AXIS_W-1:0];
      REG_AXIS_Z:     axis_vec[2] = val[AXIS_W-1:0];
      REG_RADIUS_SQ:  radius_sq = val[RSQ_W-1:0];
      REG_EDGE_LABEL: own_label = val[EDGE_LABEL_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_capsule(int hx, int hy, int hz, int ax, int ay, int az,
                             longint rsq, int lbl, bit dirty);
    @(posedge clk_i);
    write_reg(REG_HEAD_X, pad_word(hx, COORD_W, dirty));
    write_reg(REG_HEAD_Y, pad_word(hy, COORD_W, dirty));
    write_reg(REG_HEAD_Z, pad_word(hz, COORD_W, dirty));
    write_reg(REG_AXIS_X, pad_word(ax, AXIS_W, dirty));
    write_reg(REG_AXIS_Y, pad_word(ay, AXIS_W, dirty));
    write_reg(REG_AXIS_Z, pad_word(az, AXIS_W, dirty));
    write_reg(REG_RADIUS_SQ, pad_word(rsq, RSQ_W, dirty));
    write_reg(REG_EDGE_LABEL, pad_word(lbl, EDGE_LABEL_W, dirty));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // pipeline is 7 deep; let it settle before touching registers
  task automatic drain();
    while (voxel_queue.size() > 0 || s_axis_tvalid || expected_codes.size() > 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    $display("MISMATCH word %0d %s: expected %0h, got %0h", results_seen, what, want, got);
  endtask

  task automatic check_result(logic [OUT_TDATA_W-1:0] word);
    hit_e want;
    logic want_in;
    results_seen++;
    if (expected_codes.size() == 0) begin
      report_mismatch("unexpected word", '0, word);
      return;
    end
    want = expected_codes.pop_front();
    want_in = (want >= HIT_LABEL && want <= HIT_CYL);
    hit_seen[int'(want)]++;
    if (word[0] !== want_in) report_mismatch("in_region", want_in, word[0]);
    if (word[3:1] !== want) report_mismatch("hit_code", want, word[3:1]);
    if (word[OUT_TDATA_W-1:4] !== '0) report_mismatch("padding", '0, word);
  endtask

  // sender: next word goes out once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_codes.push_back(classify_voxel(voxel_t'(s_axis_tdata)));
        voxels_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (voxel_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= voxel_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int     hx, hy, hz, ax, ay, az, r, lbl;
    longint rsq;
    send_gap_pct = 8;
    recv_stall_pct = 73;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: zero capsule, edge label 2
    @(negedge clk_i);
    queue_voxel(0, 12345, -321, 77);
    queue_voxel(2, 1, 2, 3);
    queue_voxel(16'h0102, 0, 0, 0);
    queue_voxel(3, 1, 0, 0);
    drain();

    // x-aligned capsule, radius 160; boundaries are inside
    set_capsule(100, -200, 300, 1600, 0, 0, 25600, 7, 1'b0);
    near_span = 160;
    @(negedge clk_i);
    queue_voxel(7, 5000, 5000, 5000);
    queue_voxel(0, 100, -200, 300);
    queue_voxel(16'h0107, -32768, -32768, -32768);
    queue_voxel(16'hFFFF, 32767, 32767, 32767);
    queue_voxel(9, 100, -40, 300);
    queue_voxel(9, -61, -200, 300);
    queue_voxel(9, 1860, -200, 300);
    queue_voxel(9, 1861, -200, 300);
    queue_voxel(9, 900, -40, 300);
    queue_voxel(9, 900, -39, 300);
    queue_voxel(9, 500, -100, 200);
    drain();

    // largest radius, extreme head and axis
    set_capsule(-32768, 32767, -32768, 65535, -65535, 65535, 64'h3_FFFF_FFFF, 255, 1'b1);
    @(negedge clk_i);
    queue_voxel(255, 0, 0, 0);
    queue_voxel(16'h01FF, 32767, -32768, 32767);
    queue_voxel(16'h8000, 0, 0, 0);
    drain();

    // zero radius: only exact head, tail and on-axis points hit
    set_capsule(32767, 32767, 32767, -65535, -65535, -65535, 0, 2, 1'b0);
    @(negedge clk_i);
    queue_voxel(5, 32767, 32767, 32767);
    queue_voxel(5, -32768, -32768, -32768);
    queue_voxel(5, 0, 0, 0);
    queue_voxel(5, 1, 0, 0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        send_gap_pct = 8;
        recv_stall_pct = 73;
      end else if (p < 7) begin
        send_gap_pct = 73;
        recv_stall_pct = 8;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      if (p % 3 == 0) begin
        hx = $urandom_range(65535) - 32768;
        hy = $urandom_range(65535) - 32768;
        hz = $urandom_range(65535) - 32768;
        ax = $urandom_range(131070) - 65535;
        ay = $urandom_range(131070) - 65535;
        az = $urandom_range(131070) - 65535;
        r = ($urandom_range(1) != 0) ? $urandom_range(131071) : $urandom_range(1, 3000);
      end else begin
        hx = $urandom_range(40000) - 20000;
        hy = $urandom_range(40000) - 20000;
        hz = $urandom_range(40000) - 20000;
        ax = $urandom_range(24000) - 12000;
        ay = $urandom_range(24000) - 12000;
        az = $urandom_range(24000) - 12000;
        r = $urandom_range(16, 3000);
      end
      if (p == 6) begin
        ax = 0;
        ay = 0;
        az = 0;
      end
      lbl = $urandom_range(2, 255);
      // edge labels 0 and 1 fall outside the normal range
      if (p == 5) lbl = 0;
      if (p == 8) lbl = 1;
      rsq = longint'(r) * r;
      set_capsule(hx, hy, hz, ax, ay, az, rsq, lbl, p[0]);
      near_span = r;
      @(negedge clk_i);
      repeat (PHASE_LEN) voxel_queue.push_back(random_voxel());
      if (p == 2 || p == 8) begin
        // long output stall while input keeps coming: pipeline must back up
        fork
          begin
            rx_hold <= 1'b1;
            repeat (80) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
      end
      drain();
    end

    $display("Sent %0d voxels under reset defaults and %0d capsule settings, %0d words back",
             voxels_sent, settings_used, results_seen);
    $display("Codes: bg %0d, label %0d, head %0d, tail %0d, cylinder %0d, outside %0d",
             hit_seen[0], hit_seen[1], hit_seen[2], hit_seen[3], hit_seen[4], hit_seen[5]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
